// ===== rtl/core/cft_pkg.sv =====
// Shared types, constants and the element symbol table for the formula tokenizer.
`default_nettype none

package cft_pkg;

   // Width of an atomic number on the result side.
   localparam int Z_WIDTH = 6;

   // Saturation limit of the count and total result fields.
   localparam int FIELD_MAX = 65535;

   // Radix of the count digits.
   localparam int DEC_BASE = 10;

   // Character codes used by the classifier.
   localparam logic [7:0] CHAR_UPPER_A = "A";
   localparam logic [7:0] CHAR_UPPER_Z = "Z";
   localparam logic [7:0] CHAR_LOWER_A = "a";
   localparam logic [7:0] CHAR_LOWER_Z = "z";
   localparam logic [7:0] CHAR_ZERO    = "0";
   localparam logic [7:0] CHAR_NINE    = "9";
   localparam logic [7:0] CHAR_NONE    = 8'd0;

   // Result error codes.
   typedef enum logic [1:0] {
      ERR_NONE            = 2'd0,
      ERR_INVALID_CHAR    = 2'd1,
      ERR_UNKNOWN_ELEMENT = 2'd2
   } err_code_type;

   // One classified token operation from the parser to the totals stage.
   typedef struct packed {
      err_code_type       err;
      logic [Z_WIDTH-1:0] z;
      logic               last;
   } op_type;

   // Maps a one- or two-letter symbol to its atomic number, 0 if unknown.
   function automatic logic [Z_WIDTH-1:0] sym_lookup(input logic [7:0] c1,
                                                      input logic [7:0] c2);
      logic [Z_WIDTH-1:0] z;
      unique case ({c1, c2})
         {"H", CHAR_NONE}: z = 6'd1;
         "He":             z = 6'd2;
         "Li":             z = 6'd3;
         "Be":             z = 6'd4;
         {"B", CHAR_NONE}: z = 6'd5;
         {"C", CHAR_NONE}: z = 6'd6;
         {"N", CHAR_NONE}: z = 6'd7;
         {"O", CHAR_NONE}: z = 6'd8;
         {"F", CHAR_NONE}: z = 6'd9;
         "Ne":             z = 6'd10;
         "Na":             z = 6'd11;
         "Mg":             z = 6'd12;
         "Al":             z = 6'd13;
         "Si":             z = 6'd14;
         {"P", CHAR_NONE}: z = 6'd15;
         {"S", CHAR_NONE}: z = 6'd16;
         "Cl":             z = 6'd17;
         "Ar":             z = 6'd18;
         {"K", CHAR_NONE}: z = 6'd19;
         "Ca":             z = 6'd20;
         "Br":             z = 6'd35;
         {"I", CHAR_NONE}: z = 6'd53;
         default:          z = 6'd0;
      endcase
      return z;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/chemical_formula_tokenizer.sv =====
// Top level of the chemical formula tokenizer.
// Usage:
//   The req channel takes one ASCII character per beat in req_tdata, with
//   req_tlast set on the last character of a formula. The rsp channel gives
//   one beat per completed token or error: element, count and running total
//   of that element within the formula, an error code, and rsp_tlast on the
//   last result of a formula or on any error. After an error the remaining
//   characters of that formula are dropped without results.
//   Throughput: one character per cycle while the queue has room; a
//   character that completes two results holds the parser while the
//   second waits in the hold register, because the parser places one
//   operation per cycle into its four-entry queue. The totals stage
//   delivers one result per cycle while the receiver takes each beat,
//   through a read-modify-write of its RAM.
//   Reset clears the parser, the queue, the presence bits of all element
//   totals and the output register; no clearing pass is needed.
//   When the receiver stalls, the output register holds its beat, the
//   queue fills, and req_tready falls once the queue is full.
`default_nettype none

module chemical_formula_tokenizer #(
   parameter int ELEMENT_SLOTS = 64,
   parameter int COUNT_WIDTH   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tlast,   // final_char
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,   // [5:0] element_z, [21:6] token_count,
                                          // [37:22] element_total, [39:38] zero
   output logic      [2:0]  rsp_tuser,   // [0] token_valid, [2:1] error_code
   output logic             rsp_tlast    // end_of_formula
);

   localparam int QueueDepth = 4;
   localparam int OpBits     = $bits(cft_pkg::op_type);
   localparam int EntryW     = OpBits + COUNT_WIDTH;

   logic                        f_valid, f_ready;
   cft_pkg::op_type             f_op;
   logic [COUNT_WIDTH-1:0]      f_cnt;
   logic                        q_valid, q_ready;
   logic [EntryW-1:0]           q_data;
   cft_pkg::op_type             q_op;
   logic [COUNT_WIDTH-1:0]      q_cnt;

   logic                        r_token_valid;
   logic [cft_pkg::Z_WIDTH-1:0] r_z;
   logic [15:0]                 r_count, r_total;
   cft_pkg::err_code_type       r_err;

   // Parser front end.
   cft_front #(
      .ELEMENT_SLOTS (ELEMENT_SLOTS),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .char_valid (req_tvalid),
      .char_ready (req_tready),
      .char_code  (req_tdata),
      .char_final (req_tlast),
      .op_valid   (f_valid),
      .op_ready   (f_ready),
      .op_data    (f_op),
      .op_cnt     (f_cnt)
   );

   // Operation queue between front and back.
   cft_queue #(
      .WIDTH (EntryW),
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_cnt, f_op}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   assign q_op  = cft_pkg::op_type'(q_data[OpBits-1:0]);
   assign q_cnt = q_data[EntryW-1:OpBits];

   // Totals and output back end.
   cft_back #(
      .ELEMENT_SLOTS (ELEMENT_SLOTS),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .op_valid        (q_valid),
      .op_ready        (q_ready),
      .op_data         (q_op),
      .op_cnt          (q_cnt),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_token_valid (r_token_valid),
      .rsp_z           (r_z),
      .rsp_count       (r_count),
      .rsp_total       (r_total),
      .rsp_err         (r_err),
      .rsp_last        (rsp_tlast)
   );

   // Result beat packing.
   assign rsp_tdata = {2'b00, r_total, r_count, r_z};
   assign rsp_tuser = {r_err, r_token_valid};

endmodule

`default_nettype wire

// ===== rtl/core/cft_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module cft_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cft_queue.sv =====
// Small register FIFO between the parser front and the totals back end.
`default_nettype none

module cft_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CntW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   // Occupancy never runs past the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue occupancy exceeds depth");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/cft_front.sv =====
// Character classifier and token parser that feeds token operations to the queue.
`default_nettype none

module cft_front #(
   parameter int ELEMENT_SLOTS = 64,
   parameter int COUNT_WIDTH   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   char_valid,
   output logic                        char_ready,
   input  wire logic [7:0]             char_code,
   input  wire logic                   char_final,
   output logic                        op_valid,
   input  wire logic                   op_ready,
   output cft_pkg::op_type             op_data,
   output logic      [COUNT_WIDTH-1:0] op_cnt
);

   localparam int AccExtW = COUNT_WIDTH + 4;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_UPPER,
      PH_LOWER,
      PH_DIGITS
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [7:0]                        first_ff, first_in;
   logic [7:0]                        second_ff, second_in;
   logic [COUNT_WIDTH-1:0]            acc_ff, acc_in;
   logic                              skip_ff, skip_in;
   logic                              held_valid_ff, held_valid_in;
   cft_pkg::op_type                   held_op_ff, held_op_in;
   logic [COUNT_WIDTH-1:0]            held_cnt_ff, held_cnt_in;

   cft_pkg::op_type                   op_ar [2];
   logic [COUNT_WIDTH-1:0]            cnt_ar [2];
   logic [1:0]                        n_ops;

   logic                              accept;
   logic                              is_upper, is_lower, is_digit;
   logic [3:0]                        digit_val;
   logic [AccExtW-1:0]                acc_ext;
   logic [COUNT_WIDTH-1:0]            acc_sat;
   logic [cft_pkg::Z_WIDTH-1:0]       pend_z;
   logic                              pend_bad;
   logic [COUNT_WIDTH-1:0]            pend_cnt;

   assign char_ready = !held_valid_ff && op_ready;
   assign accept     = char_valid && char_ready;

   // Character classes; codes above 127 fall in none of them.
   assign is_upper = (char_code >= cft_pkg::CHAR_UPPER_A) && (char_code <= cft_pkg::CHAR_UPPER_Z);
   assign is_lower = (char_code >= cft_pkg::CHAR_LOWER_A) && (char_code <= cft_pkg::CHAR_LOWER_Z);
   assign is_digit = (char_code >= cft_pkg::CHAR_ZERO) && (char_code <= cft_pkg::CHAR_NINE);

   // Decimal accumulate with saturation at the count width.
   assign digit_val = 4'(char_code - cft_pkg::CHAR_ZERO);
   assign acc_ext   = AccExtW'(acc_ff) * AccExtW'(cft_pkg::DEC_BASE) + AccExtW'(digit_val);
   assign acc_sat   = (acc_ext[AccExtW-1:COUNT_WIDTH] != '0) ? '1 : acc_ext[COUNT_WIDTH-1:0];

   // The token that is pending before this character.
   assign pend_z   = cft_pkg::sym_lookup(first_ff, second_ff);
   assign pend_bad = (pend_z == '0) || (int'(pend_z) >= ELEMENT_SLOTS);
   assign pend_cnt = (acc_ff == '0) ? COUNT_WIDTH'(1) : acc_ff;

   // Parse one character into zero, one or two token operations.
   always_comb begin : parse
      logic [cft_pkg::Z_WIDTH-1:0] fin_z;
      logic                        fin_bad;
      logic [COUNT_WIDTH-1:0]      fin_cnt;
      logic                        fin_now;
      logic                        stop;

      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      acc_in    = acc_ff;
      skip_in   = skip_ff;
      n_ops     = 2'd0;
      op_ar[0]  = '{err: cft_pkg::ERR_NONE, z: '0, last: 1'b0};
      op_ar[1]  = '{err: cft_pkg::ERR_NONE, z: '0, last: 1'b0};
      cnt_ar[0] = '0;
      cnt_ar[1] = '0;
      fin_now   = 1'b0;
      stop      = 1'b0;
      fin_z     = '0;
      fin_bad   = 1'b0;
      fin_cnt   = '0;

      if (accept) begin
         if (skip_ff) begin
            // Dropping the rest of a failed formula.
            if (char_final) begin
               skip_in  = 1'b0;
               phase_in = PH_IDLE;
            end
         end else begin
            if (phase_ff == PH_UPPER && is_lower) begin
               second_in = char_code;
               phase_in  = PH_LOWER;
               fin_now   = char_final;
            end else if (phase_ff != PH_IDLE && is_digit) begin
               acc_in   = acc_sat;
               phase_in = PH_DIGITS;
               fin_now  = char_final;
            end else begin
               // Any other character closes the pending token.
               if (phase_ff != PH_IDLE) begin
                  phase_in = PH_IDLE;
                  n_ops    = 2'd1;
                  if (pend_bad) begin
                     op_ar[0] = '{err: cft_pkg::ERR_UNKNOWN_ELEMENT, z: '0, last: 1'b1};
                     skip_in  = !char_final;
                     stop     = 1'b1;
                  end else begin
                     op_ar[0]  = '{err: cft_pkg::ERR_NONE, z: pend_z, last: 1'b0};
                     cnt_ar[0] = pend_cnt;
                  end
               end
               if (!stop) begin
                  if (is_upper) begin
                     first_in  = char_code;
                     second_in = cft_pkg::CHAR_NONE;
                     acc_in    = '0;
                     phase_in  = PH_UPPER;
                     fin_now   = char_final;
                  end else begin
                     op_ar[n_ops[0]]  = '{err: cft_pkg::ERR_INVALID_CHAR, z: '0, last: 1'b1};
                     cnt_ar[n_ops[0]] = '0;
                     n_ops            = n_ops + 2'd1;
                     phase_in         = PH_IDLE;
                     skip_in          = !char_final;
                  end
               end
            end

            // The final character closes whatever token it leaves behind.
            fin_z   = cft_pkg::sym_lookup(first_in, second_in);
            fin_bad = (fin_z == '0) || (int'(fin_z) >= ELEMENT_SLOTS);
            fin_cnt = (acc_in == '0) ? COUNT_WIDTH'(1) : acc_in;
            if (fin_now) begin
               phase_in = PH_IDLE;
               if (fin_bad) begin
                  op_ar[n_ops[0]]  = '{err: cft_pkg::ERR_UNKNOWN_ELEMENT, z: '0, last: 1'b1};
                  cnt_ar[n_ops[0]] = '0;
               end else begin
                  op_ar[n_ops[0]]  = '{err: cft_pkg::ERR_NONE, z: fin_z, last: 1'b1};
                  cnt_ar[n_ops[0]] = fin_cnt;
               end
               n_ops = n_ops + 2'd1;
            end
         end
      end
   end

   // A second operation waits in the hold register for the next queue slot.
   assign held_valid_in = held_valid_ff ? !op_ready : (n_ops == 2'd2);
   assign held_op_in    = held_valid_ff ? held_op_ff : op_ar[1];
   assign held_cnt_in   = held_valid_ff ? held_cnt_ff : cnt_ar[1];

   assign op_valid = held_valid_ff || (n_ops != 2'd0);
   assign op_data  = held_valid_ff ? held_op_ff : op_ar[0];
   assign op_cnt   = held_valid_ff ? held_cnt_ff : cnt_ar[0];

   // Parser state and the hold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         skip_ff       <= 1'b0;
         held_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         skip_ff       <= skip_in;
         held_valid_ff <= held_valid_in;
      end
      first_ff    <= first_in;
      second_ff   <= second_in;
      acc_ff      <= acc_in;
      held_op_ff  <= held_op_in;
      held_cnt_ff <= held_cnt_in;
   end

`ifndef SYNTH
   // A final character always leaves the parser idle and out of skip mode.
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      accept && char_final |=> phase_ff == PH_IDLE && !skip_ff)
      else $error("parser not idle after final character");

   // Characters dropped after an error never produce operations.
   a_skip_silent: assert property (@(posedge clock) disable iff (reset)
      accept && skip_ff |-> n_ops == 2'd0)
      else $error("operation produced while skipping");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/cft_back.sv =====
// Per-formula element totals and the result output register.
`default_nettype none

module cft_back #(
   parameter int ELEMENT_SLOTS = 64,
   parameter int COUNT_WIDTH   = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        op_valid,
   output logic                             op_ready,
   input  wire cft_pkg::op_type             op_data,
   input  wire logic [COUNT_WIDTH-1:0]      op_cnt,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_token_valid,
   output logic      [cft_pkg::Z_WIDTH-1:0] rsp_z,
   output logic      [15:0]                 rsp_count,
   output logic      [15:0]                 rsp_total,
   output cft_pkg::err_code_type            rsp_err,
   output logic                             rsp_last
);

   localparam int IdxW = $clog2(ELEMENT_SLOTS);
   localparam logic [COUNT_WIDTH-1:0] FieldCap = COUNT_WIDTH'(cft_pkg::FIELD_MAX);

   // Clamps a count-width value into a 16-bit result field.
   function automatic logic [15:0] sat_field(input logic [COUNT_WIDTH-1:0] v);
      return (v > FieldCap) ? 16'hFFFF : 16'(v);
   endfunction

   logic                         b_valid_ff;
   cft_pkg::op_type              b_op_ff;
   logic [COUNT_WIDTH-1:0]       b_cnt_ff;
   logic                         fwd_valid_ff;
   logic [IdxW-1:0]              fwd_idx_ff;
   logic [COUNT_WIDTH-1:0]       fwd_total_ff;
   logic [ELEMENT_SLOTS-1:0]     present_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_tok_ff;
   logic [cft_pkg::Z_WIDTH-1:0]  rsp_z_ff;
   logic [15:0]                  rsp_count_ff;
   logic [15:0]                  rsp_total_ff;
   cft_pkg::err_code_type        rsp_err_ff;
   logic                         rsp_last_ff;

   logic                         out_load, pop, wr_en, is_token, fwd_hit;
   logic [IdxW-1:0]              rd_idx, b_idx;
   logic [COUNT_WIDTH-1:0]       ram_rdata, base, total;
   logic [COUNT_WIDTH:0]         sum;

   // Handshakes through the stage and the output register.
   assign out_load = b_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign op_ready = !b_valid_ff || out_load;
   assign pop      = op_valid && op_ready;
   assign is_token = (b_op_ff.err == cft_pkg::ERR_NONE);
   assign wr_en    = out_load && is_token;

   assign rd_idx = IdxW'(op_data.z);
   assign b_idx  = IdxW'(b_op_ff.z);

   cft_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (ELEMENT_SLOTS)
   ) u_totals (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_idx),
      .wr_data (total),
      .rd_en   (pop),
      .rd_addr (rd_idx),
      .rd_data (ram_rdata)
   );

   // Running total: an absent entry reads as zero; a write made while this
   // token's read was in flight is taken from the bypass register.
   assign fwd_hit = fwd_valid_ff && (fwd_idx_ff == b_idx);
   assign base    = !present_ff[b_idx] ? '0 : (fwd_hit ? fwd_total_ff : ram_rdata);
   assign sum     = {1'b0, base} + {1'b0, b_cnt_ff};
   assign total   = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

   // Stage register, bypass register and presence bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         present_ff   <= '0;
      end else begin
         if (op_ready) begin
            b_valid_ff <= op_valid;
         end
         if (pop) begin
            fwd_valid_ff <= wr_en;
         end
         if (out_load && b_op_ff.last) begin
            present_ff <= '0;
         end else if (wr_en) begin
            present_ff[b_idx] <= 1'b1;
         end
      end
      if (pop) begin
         b_op_ff      <= op_data;
         b_cnt_ff     <= op_cnt;
         fwd_idx_ff   <= b_idx;
         fwd_total_ff <= total;
      end
   end

   // Output register holds a result until the receiver takes the beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_tok_ff   <= is_token;
         rsp_z_ff     <= is_token ? b_op_ff.z : '0;
         rsp_count_ff <= is_token ? sat_field(b_cnt_ff) : '0;
         rsp_total_ff <= is_token ? sat_field(total) : '0;
         rsp_err_ff   <= b_op_ff.err;
         rsp_last_ff  <= b_op_ff.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_token_valid = rsp_tok_ff;
   assign rsp_z           = rsp_z_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_total       = rsp_total_ff;
   assign rsp_err         = rsp_err_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   // A token written to the totals always carries a count of at least one.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> b_cnt_ff != '0)
      else $error("token with zero count");

   // The end of a formula leaves no element total behind.
   a_clear_at_end: assert property (@(posedge clock) disable iff (reset)
      out_load && b_op_ff.last |=> present_ff == '0)
      else $error("totals not cleared at end of formula");

   // Error operations never name an element.
   a_err_no_elem: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !is_token |-> b_op_ff.z == '0 && b_op_ff.last)
      else $error("error operation carries an element or no end mark");
`endif

endmodule

`default_nettype wire
